[hdl/ilt_pkg.sv]
// ilt_pkg: operation, status and sequencer state codes for the indexed list table
// no dependencies; used by indexed_list_table
package ilt_pkg;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_READ   = 3'd4,
        OP_WRITE  = 3'd5,
        OP_FIND   = 3'd6,
        OP_CLEAR  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_READ  = 3'd1,
        S_SHIFT = 3'd2,
        S_TAIL  = 3'd3,
        S_FIND  = 3'd4
    } state_t;

endpackage

[hdl/ilt_mem.sv]
// ilt_mem: entry storage, one write port and one read port, registered read data
// no dependencies; instantiated by indexed_list_table
module ilt_mem #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32,
    parameter int AW         = 6
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WORD_WIDTH-1:0] wdata,
    input  logic [AW-1:0]         raddr,
    output logic [WORD_WIDTH-1:0] rdata
);

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hdl/indexed_list_table.sv]
// indexed_list_table: fixed-capacity ordered word list with insert, erase and search
// depends on ilt_pkg and ilt_mem
// sequencing: append, write, clear, insert at the tail, erase of the last entry, find on
//   an empty list and refused requests strobe done straight from idle; pop and read pass
//   through S_READ; other inserts walk S_SHIFT then S_TAIL, other erases walk S_SHIFT,
//   and find walks S_FIND up to a hit or the last entry; one transaction at a time, with
//   entries moved or compared one by one through the entry memory's single read and write port
// reset: rst_n clears the count and the sequencer; stored words are not cleared
// the result is shown for one cycle on done and cannot be held off; a new start
//   may be taken in that same cycle
module indexed_list_table #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [6:0]  position_in,
    input  logic [31:0] word_in,
    output logic        done,
    output logic [31:0] word_out,
    output logic        found,
    output logic [5:0]  found_position,
    output logic [6:0]  entry_count,
    output logic [1:0]  status
);

    // address, count and compare widths
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    // control state
    ilt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            done_reg, done_next;

    // transaction payload and walk pointers
    ilt_pkg::op_t          op_reg, op_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]         end_reg, end_next;

    // result registers
    logic [31:0]       word_out_reg, word_out_next;
    logic              found_reg, found_next;
    logic [5:0]        fpos_reg, fpos_next;
    ilt_pkg::status_t  status_reg, status_next;

    // memory port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    // request decode
    logic            accept;
    ilt_pkg::op_t    op_in;
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   cnt_ext;
    logic [CW-1:0]   cnt_dec;
    logic [AW-1:0]   pos_addr;
    logic [AW-1:0]   last_addr;
    logic            is_full;
    logic            is_empty;
    logic            pos_lt_cnt;
    logic            pos_le_cnt;
    logic            walk_last;
    logic            hit;

    assign accept     = start && (state_reg == ilt_pkg::S_IDLE);
    assign op_in      = ilt_pkg::op_t'(func);
    assign pos_ext    = PW'(position_in);
    assign cnt_ext    = PW'(count_reg);
    assign cnt_dec    = count_reg - CW'(1);
    assign pos_addr   = pos_ext[AW-1:0];
    assign last_addr  = cnt_dec[AW-1:0];
    assign is_full    = (count_reg == CW'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign pos_lt_cnt = (pos_ext < cnt_ext);
    assign pos_le_cnt = (pos_ext <= cnt_ext);
    assign walk_last  = (rd_ptr_reg == end_reg);
    assign hit        = (mem_rdata == word_reg);

    ilt_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .AW         (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ilt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        ilt_pkg::OP_POP:
                        begin
                            if (!is_empty)
                                state_next = ilt_pkg::S_READ;
                        end
                        ilt_pkg::OP_INSERT:
                        begin
                            // insert at the tail needs no walk
                            if (pos_le_cnt && !is_full && pos_lt_cnt)
                                state_next = ilt_pkg::S_SHIFT;
                        end
                        ilt_pkg::OP_ERASE:
                        begin
                            // erase of the last entry needs no walk
                            if (pos_lt_cnt && (pos_addr != last_addr))
                                state_next = ilt_pkg::S_SHIFT;
                        end
                        ilt_pkg::OP_READ:
                        begin
                            if (pos_lt_cnt)
                                state_next = ilt_pkg::S_READ;
                        end
                        ilt_pkg::OP_FIND:
                        begin
                            if (!is_empty)
                                state_next = ilt_pkg::S_FIND;
                        end
                        default:
                        begin
                            state_next = ilt_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ilt_pkg::S_READ:
            begin
                state_next = ilt_pkg::S_IDLE;
            end
            ilt_pkg::S_SHIFT:
            begin
                if (walk_last)
                begin
                    if (op_reg == ilt_pkg::OP_INSERT)
                        state_next = ilt_pkg::S_TAIL;
                    else
                        state_next = ilt_pkg::S_IDLE;
                end
            end
            ilt_pkg::S_TAIL:
            begin
                state_next = ilt_pkg::S_IDLE;
            end
            ilt_pkg::S_FIND:
            begin
                if (hit || walk_last)
                    state_next = ilt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ilt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory port and results
    always_comb
    begin
        count_next    = count_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        word_next     = word_reg;
        rd_ptr_next   = rd_ptr_reg;
        end_next      = end_reg;
        word_out_next = word_out_reg;
        found_next    = found_reg;
        fpos_next     = fpos_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = rd_ptr_reg;
        mem_wdata     = word_reg;
        mem_raddr     = rd_ptr_reg;
        case (state_reg)
            ilt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = op_in;
                    word_next     = WORD_WIDTH'(word_in);
                    word_out_next = '0;
                    found_next    = 1'b0;
                    fpos_next     = '0;
                    status_next   = ilt_pkg::STAT_OK;
                    case (op_in)
                        ilt_pkg::OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ilt_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = WORD_WIDTH'(word_in);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ilt_pkg::OP_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = ilt_pkg::STAT_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                count_next = cnt_dec;
                                mem_raddr  = last_addr;
                            end
                        end
                        ilt_pkg::OP_INSERT:
                        begin
                            if (!pos_le_cnt)
                            begin
                                status_next = ilt_pkg::STAT_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (is_full)
                            begin
                                status_next = ilt_pkg::STAT_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                if (!pos_lt_cnt)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = pos_addr;
                                    mem_wdata = WORD_WIDTH'(word_in);
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    // walk down from the last entry
                                    mem_raddr   = last_addr;
                                    rd_ptr_next = last_addr;
                                    end_next    = pos_addr;
                                end
                            end
                        end
                        ilt_pkg::OP_ERASE:
                        begin
                            if (!pos_lt_cnt)
                            begin
                                status_next = ilt_pkg::STAT_RANGE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                count_next = cnt_dec;
                                if (pos_addr == last_addr)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    // walk up from the entry after the hole
                                    mem_raddr   = pos_addr + AW'(1);
                                    rd_ptr_next = pos_addr + AW'(1);
                                    end_next    = last_addr;
                                end
                            end
                        end
                        ilt_pkg::OP_READ:
                        begin
                            if (!pos_lt_cnt)
                            begin
                                status_next = ilt_pkg::STAT_RANGE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_raddr = pos_addr;
                            end
                        end
                        ilt_pkg::OP_WRITE:
                        begin
                            done_next = 1'b1;
                            if (!pos_lt_cnt)
                            begin
                                status_next = ilt_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_addr;
                                mem_wdata = WORD_WIDTH'(word_in);
                            end
                        end
                        ilt_pkg::OP_FIND:
                        begin
                            if (is_empty)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                mem_raddr   = '0;
                                rd_ptr_next = '0;
                                end_next    = last_addr;
                            end
                        end
                        ilt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ilt_pkg::S_READ:
            begin
                word_out_next = 32'(mem_rdata);
                done_next     = 1'b1;
            end
            ilt_pkg::S_SHIFT:
            begin
                // move the word read last cycle one place; read and write addresses differ
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (op_reg == ilt_pkg::OP_INSERT)
                    mem_waddr = rd_ptr_reg + AW'(1);
                else
                    mem_waddr = rd_ptr_reg - AW'(1);
                if (!walk_last)
                begin
                    if (op_reg == ilt_pkg::OP_INSERT)
                    begin
                        mem_raddr   = rd_ptr_reg - AW'(1);
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                    end
                    else
                    begin
                        mem_raddr   = rd_ptr_reg + AW'(1);
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
                else if (op_reg != ilt_pkg::OP_INSERT)
                begin
                    done_next = 1'b1;
                end
            end
            ilt_pkg::S_TAIL:
            begin
                // drop the new word into the opened slot
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = word_reg;
                done_next = 1'b1;
            end
            ilt_pkg::S_FIND:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    fpos_next  = 6'(rd_ptr_reg);
                    done_next  = 1'b1;
                end
                else if (walk_last)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    mem_raddr   = rd_ptr_reg + AW'(1);
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilt_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        word_reg     <= word_next;
        rd_ptr_reg   <= rd_ptr_next;
        end_reg      <= end_next;
        word_out_reg <= word_out_next;
        found_reg    <= found_next;
        fpos_reg     <= fpos_next;
        status_reg   <= status_next;
    end

    assign busy           = (state_reg != ilt_pkg::S_IDLE);
    assign done           = done_reg;
    assign word_out       = word_out_reg;
    assign found          = found_reg;
    assign found_position = fpos_reg;
    assign entry_count    = 7'(count_reg);
    assign status         = status_reg;

    // the count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    // an accepted transaction either finishes at once or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done_reg))
        else $error("accepted transaction vanished");

    // the memory is only written by a transaction in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (busy || accept))
        else $error("memory write while idle");

    // a search never modifies the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ilt_pkg::S_FIND) |-> !mem_we)
        else $error("memory write during find");

    // a full refusal only reports on a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ilt_pkg::STAT_FULL)) |-> is_full)
        else $error("full status on a list with room");

endmodule

[tb/sv/testbench.sv]
// testbench for indexed_list_table: directed and random list requests over a start/busy
// command port, with each done strobe checked against an internal list predictor
// depends on ilt_pkg and indexed_list_table
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 64;

    // one result as the block reports it on a done strobe
    typedef struct packed {
        logic [31:0]      word;
        logic             hit;
        logic [5:0]       hit_pos;
        logic [6:0]       count;
        ilt_pkg::status_t st;
    } list_result_t;

    // dut ports; every input is known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  func = ilt_pkg::OP_APPEND;
    logic [6:0]  position_in = 7'd0;
    logic [31:0] word_in = 32'd0;
    logic        done;
    logic [31:0] word_out;
    logic        found;
    logic [5:0]  found_position;
    logic [6:0]  entry_count;
    logic [1:0]  status;

    // predictor state: the words of the list and how many are live
    logic [31:0] list_words [LIST_DEPTH];
    logic [6:0]  list_len;

    // results predicted at acceptance, oldest first
    list_result_t pending_results [$];
    list_result_t oldest_result;

    int errors = 0;
    int sent_count = 0;
    int checked_count = 0;
    int idle_pct = 0;
    int op_seen [8];
    int status_seen [4];

    indexed_list_table u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .position_in    (position_in),
        .word_in        (word_in),
        .done           (done),
        .word_out       (word_out),
        .found          (found),
        .found_position (found_position),
        .entry_count    (entry_count),
        .status         (status)
    );

    always #10 clk = ~clk;

    // applies one request to the predicted list and returns the expected result
    // refused requests leave the list untouched
    function automatic list_result_t predict_list_op(input ilt_pkg::op_t f,
                                                     input logic [6:0] pos,
                                                     input logic [31:0] w);
        list_result_t r;
        int i;
        r = '0;
        r.st = ilt_pkg::STAT_OK;
        case (f)
            ilt_pkg::OP_APPEND:
            begin
                if (list_len >= LIST_DEPTH)
                    r.st = ilt_pkg::STAT_FULL;
                else
                begin
                    list_words[list_len[5:0]] = w;
                    list_len = list_len + 7'd1;
                end
            end
            ilt_pkg::OP_POP:
            begin
                if (list_len == 0)
                    r.st = ilt_pkg::STAT_EMPTY;
                else
                begin
                    list_len = list_len - 7'd1;
                    r.word = list_words[list_len[5:0]];
                end
            end
            ilt_pkg::OP_INSERT:
            begin
                // position is checked before fullness
                if (pos > list_len)
                    r.st = ilt_pkg::STAT_RANGE;
                else if (list_len >= LIST_DEPTH)
                    r.st = ilt_pkg::STAT_FULL;
                else
                begin
                    for (i = int'(list_len); i > pos; i--)
                        list_words[6'(i)] = list_words[6'(i - 1)];
                    list_words[pos[5:0]] = w;
                    list_len = list_len + 7'd1;
                end
            end
            ilt_pkg::OP_ERASE:
            begin
                if (pos >= list_len)
                    r.st = ilt_pkg::STAT_RANGE;
                else
                begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_words[6'(i)] = list_words[6'(i + 1)];
                    list_len = list_len - 7'd1;
                end
            end
            ilt_pkg::OP_READ:
            begin
                if (pos >= list_len)
                    r.st = ilt_pkg::STAT_RANGE;
                else
                    r.word = list_words[pos[5:0]];
            end
            ilt_pkg::OP_WRITE:
            begin
                if (pos >= list_len)
                    r.st = ilt_pkg::STAT_RANGE;
                else
                    list_words[pos[5:0]] = w;
            end
            ilt_pkg::OP_FIND:
            begin
                // first match wins; an empty list never matches
                for (i = 0; i < list_len; i++)
                begin
                    if (!r.hit && list_words[6'(i)] == w)
                    begin
                        r.hit = 1'b1;
                        r.hit_pos = i[5:0];
                    end
                end
            end
            default:
                list_len = 7'd0;
        endcase
        r.count = list_len;
        return r;
    endfunction

    // drives one transaction and holds it until the block takes it, then predicts
    // the result; in idle phases start may drop for a random gap afterwards
    task automatic send_request(input ilt_pkg::op_t f, input logic [6:0] pos,
                                input logic [31:0] w);
        list_result_t r;
        start       <= 1'b1;
        func        <= f;
        position_in <= pos;
        word_in     <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_list_op(f, pos, w);
        pending_results = {pending_results, r};
        sent_count++;
        op_seen[f]++;
        status_seen[r.st]++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            // mostly short gaps, sometimes long enough to span a whole shift or search
            if ($urandom_range(9) < 8)
                repeat ($urandom_range(1, 4)) @(posedge clk);
            else
                repeat ($urandom_range(5, 70)) @(posedge clk);
        end
    endtask

    // result checker: every done strobe is compared with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing pending: word_out %h status %0d",
                         $time, word_out, status);
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                checked_count++;
                if (word_out !== oldest_result.word)
                begin
                    $display("%0t: word_out expected %h actual %h",
                             $time, oldest_result.word, word_out);
                    errors++;
                end
                if (found !== oldest_result.hit)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, oldest_result.hit, found);
                    errors++;
                end
                if (found_position !== oldest_result.hit_pos)
                begin
                    $display("%0t: found_position expected %0d actual %0d",
                             $time, oldest_result.hit_pos, found_position);
                    errors++;
                end
                if (entry_count !== oldest_result.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, oldest_result.count, entry_count);
                    errors++;
                end
                if (status !== oldest_result.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_result.st, status);
                    errors++;
                end
            end
        end
    end

    // every refusal on an empty list, then a first entry and the ops on it
    task automatic test_empty_list();
        idle_pct = 0;
        send_request(ilt_pkg::OP_POP, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_READ, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_ERASE, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_WRITE, 7'd0, 32'hFFFF_FFFF);
        send_request(ilt_pkg::OP_FIND, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_INSERT, 7'd1, 32'd1);
        send_request(ilt_pkg::OP_INSERT, 7'd127, 32'd1);
        send_request(ilt_pkg::OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_request(ilt_pkg::OP_READ, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_READ, 7'd1, 32'd0);
        send_request(ilt_pkg::OP_FIND, 7'd0, 32'hFFFF_FFFF);
        send_request(ilt_pkg::OP_WRITE, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_INSERT, 7'd0, 32'h8000_0000);
        send_request(ilt_pkg::OP_FIND, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_ERASE, 7'd1, 32'd0);
        send_request(ilt_pkg::OP_POP, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_CLEAR, 7'd127, 32'hFFFF_FFFF);
    endtask

    // fill to capacity, then the refusals of a full list and the longest walks
    task automatic test_full_list();
        int i;
        idle_pct = 0;
        for (i = 0; i < LIST_DEPTH; i++)
            send_request(ilt_pkg::OP_APPEND, 7'd0, (i == 0) ? 32'd0 : $urandom);
        send_request(ilt_pkg::OP_APPEND, 7'd0, 32'h5A5A_5A5A);
        send_request(ilt_pkg::OP_INSERT, 7'd64, 32'h5A5A_5A5A);
        send_request(ilt_pkg::OP_INSERT, 7'd0, 32'h5A5A_5A5A);
        send_request(ilt_pkg::OP_INSERT, 7'd65, 32'h5A5A_5A5A);
        send_request(ilt_pkg::OP_READ, 7'd63, 32'd0);
        send_request(ilt_pkg::OP_READ, 7'd64, 32'd0);
        send_request(ilt_pkg::OP_FIND, 7'd0, list_words[63]);
        send_request(ilt_pkg::OP_FIND, 7'd0, 32'h1234_5678);
        // erase and insert at the head move every entry
        send_request(ilt_pkg::OP_ERASE, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_INSERT, 7'd0, 32'hFFFF_FFFF);
        send_request(ilt_pkg::OP_WRITE, 7'd63, 32'hA5A5_A5A5);
        send_request(ilt_pkg::OP_ERASE, 7'd63, 32'd0);
        send_request(ilt_pkg::OP_POP, 7'd0, 32'd0);
        send_request(ilt_pkg::OP_CLEAR, 7'd0, 32'd0);
    endtask

    // random requests; every hundred items the mix leans toward growing, holding
    // or shrinking the list so that both full and empty are reached often
    task automatic test_random_traffic(input int n_items, input int pct);
        int k;
        int j;
        int bias;
        int roll;
        int total;
        int w [8];
        ilt_pkg::op_t f;
        logic [6:0] pos;
        logic [31:0] val;
        idle_pct = pct;
        bias = 1;
        for (k = 0; k < n_items; k++)
        begin
            if (k % 100 == 0)
                bias = $urandom_range(2);
            // weights in order append, pop, insert, erase, read, write, find, clear
            case (bias)
                0:       w = '{5, 25, 5, 25, 12, 10, 16, 2};
                2:       w = '{30, 5, 25, 5, 10, 10, 13, 2};
                default: w = '{15, 12, 15, 13, 15, 12, 16, 2};
            endcase
            roll = $urandom_range(99);
            total = 0;
            f = ilt_pkg::OP_CLEAR;
            for (j = 0; j < 8; j++)
            begin
                total += w[j];
                if (roll < total && f == ilt_pkg::OP_CLEAR && total - w[j] <= roll)
                    f = ilt_pkg::op_t'(j);
            end

            // positions mostly in range, otherwise anywhere in the 7-bit field
            pos = 7'($urandom_range(127));
            if ($urandom_range(99) < 85)
            begin
                if (f == ilt_pkg::OP_INSERT)
                    pos = 7'($urandom_range(list_len));
                else if ((f == ilt_pkg::OP_ERASE || f == ilt_pkg::OP_READ ||
                          f == ilt_pkg::OP_WRITE) && list_len != 0)
                    pos = 7'($urandom_range(list_len - 1));
            end

            // a small pool of corner words gives duplicates for find
            case ($urandom_range(9))
                0:       val = 32'd0;
                1:       val = 32'hFFFF_FFFF;
                2:       val = 32'h8000_0000;
                default: val = $urandom;
            endcase
            if (f == ilt_pkg::OP_FIND && list_len != 0 && $urandom_range(99) < 60)
                val = list_words[6'($urandom_range(list_len - 1))];

            send_request(f, pos, val);
        end
    endtask

    initial
    begin
        int drain_cycles;
        list_len = 7'd0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // single reset at the start of the run
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_full_list();
        // idle phases: none, sender idle 47 of 100, sender idle 17, none again
        test_random_traffic(300, 0);
        test_random_traffic(300, 47);
        test_random_traffic(300, 17);
        test_random_traffic(300, 0);
        start <= 1'b0;

        // drain outstanding results, then let the longest walk finish
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 2000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (80) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors += pending_results.size();
        end

        $display("%0d transactions sent, %0d results checked, %0d mismatches",
                 sent_count, checked_count, errors);
        $display("outcomes: ok %0d, out of range %0d, empty %0d, full %0d; finds %0d, clears %0d",
                 status_seen[ilt_pkg::STAT_OK], status_seen[ilt_pkg::STAT_RANGE],
                 status_seen[ilt_pkg::STAT_EMPTY], status_seen[ilt_pkg::STAT_FULL],
                 op_seen[ilt_pkg::OP_FIND], op_seen[ilt_pkg::OP_CLEAR]);
        if (errors == 0)
            $display("indexed_list_table verification clean");
        else
            $display("indexed_list_table verification failed");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial
    begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("indexed_list_table verification failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/ilt_pkg.sv
hdl/ilt_mem.sv
hdl/indexed_list_table.sv
tb/sv/testbench.sv
